// ----- rtl/stf_pkg.sv -----
// Shared constants, codes and types of the scroll tile map fetcher.
package stf_pkg;

   localparam int MAP_ENTRIES = 4096;
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);
   localparam int CODE_W      = 16;
   localparam int ATTR_W      = 7;
   localparam int ENTRY_W     = CODE_W + ATTR_W;
   localparam int WORD_W      = 16;
   localparam int ROW_W       = 6;
   localparam int ADDR_W      = 32;
   localparam int PAL_W       = 7;
   localparam int FLIP_W      = 2;
   localparam int POS_W       = 10;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_ROW   = 1'b1;

   localparam logic [5:0] COLS_LAST_8  = 6'd48;
   localparam logic [5:0] COLS_LAST_32 = 6'd12;

   localparam logic [CODE_W-1:0] QUIRK_SUB_FROM = 16'h5800;
   localparam logic [CODE_W-1:0] QUIRK_ADD_BELOW = 16'h5600;
   localparam logic [CODE_W-1:0] QUIRK_DELTA    = 16'h4000;
   localparam logic [PAL_W-1:0]  PAL_BASE_8     = 7'h20;
   localparam logic [PAL_W-1:0]  PAL_BASE_32    = 7'h60;

   typedef enum logic [2:0] {
      CSR_LAYER_MODE = 3'd0,
      CSR_SCROLL_X   = 3'd1,
      CSR_SCROLL_Y   = 3'd2,
      CSR_FIRST_LINE = 3'd3,
      CSR_END_LINE   = 3'd4,
      CSR_TILE_BASE  = 3'd5,
      CSR_CODE_QUIRK = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      QUIRK_NONE = 2'd0,
      QUIRK_SUB  = 2'd1,
      QUIRK_ADD  = 2'd2
   } quirk_type;

   // per-column data travelling alongside the map read
   typedef struct packed {
      logic             clip;
      logic             last;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
   } col_meta_type;

endpackage

// ----- rtl/stf_req_if.sv -----
// Input channel: map write and row draw items.
interface stf_req_if;
   import stf_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [MAP_AW-1:0] entry_index;
   logic [WORD_W-1:0] tile_code;
   logic [WORD_W-1:0] tile_attr;
   logic [ROW_W-1:0]  row_number;

   modport source (output valid, cmd, entry_index, tile_code, tile_attr, row_number,
                   input ready);
   modport sink (input valid, cmd, entry_index, tile_code, tile_attr, row_number,
                 output ready);
endinterface

// ----- rtl/stf_rsp_if.sv -----
// Result channel: one draw command per beat.
interface stf_rsp_if;
   import stf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ADDR_W-1:0]       tile_address;
   logic [PAL_W-1:0]        palette;
   logic [FLIP_W-1:0]       flip;
   logic signed [POS_W-1:0] screen_x;
   logic signed [POS_W-1:0] screen_y;
   logic                    needs_clip;
   logic                    last;

   modport source (output valid, tile_address, palette, flip, screen_x, screen_y,
                   needs_clip, last, input ready);
   modport sink (input valid, tile_address, palette, flip, screen_x, screen_y,
                 needs_clip, last, output ready);
endinterface

// ----- rtl/scroll_tilemap_fetch.sv -----
// Scroll layer tile fetcher: tile map memory, row walker and draw command output.
//
// Channels: req_bus takes items; cmd write stores one map entry and gives
// no beat, cmd row walks one tile row and gives one draw command beat per
// tile column on rsp_bus (49 in 8x8 mode, 13 in 32x32 mode), last set on
// the final beat. Rows outside the band give no beat. Registers are written
// over the csr_ APB port, by the user only while the block is idle; the
// block does not enforce this. A row item holds off new items until its
// walk is done, the walker issuing one map read per cycle unless stalled;
// a write item or an empty row leaves the block ready for the next item.
// The first beat passes the walker state, the read stage and the output
// register. The single map read port sets that rate of one entry per cycle.
// Stalls: the output register and a read stage hold their beats while
// rsp_bus.ready is low, and the walker pauses; nothing is lost.
// Reset: registers return to their defaults (end_line 224, all else zero),
// pipeline empties. The map is not cleared and needs no clearing pass;
// entries read before they are written give undefined commands.
module scroll_tilemap_fetch (
   input  logic                        clock,
   input  logic                        reset,
   stf_req_if.sink                     req_bus,
   stf_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [stf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [stf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [stf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import stf_pkg::*;

   // configuration registers
   logic              layer_mode_ff;
   logic [15:0]       scroll_x_ff;
   logic [15:0]       scroll_y_ff;
   logic [7:0]        first_line_ff;
   logic [7:0]        end_line_ff;
   logic [31:0]       tile_base_ff;
   logic [1:0]        code_quirk_ff;

   logic              csr_write;
   csr_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_mode_ff <= 1'b0;
         scroll_x_ff   <= '0;
         scroll_y_ff   <= '0;
         first_line_ff <= '0;
         end_line_ff   <= 8'd224;
         tile_base_ff  <= '0;
         code_quirk_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LAYER_MODE: layer_mode_ff <= csr_pwdata[0];
            CSR_SCROLL_X:   scroll_x_ff   <= csr_pwdata[15:0];
            CSR_SCROLL_Y:   scroll_y_ff   <= csr_pwdata[15:0];
            CSR_FIRST_LINE: first_line_ff <= csr_pwdata[7:0];
            CSR_END_LINE:   end_line_ff   <= csr_pwdata[7:0];
            CSR_TILE_BASE:  tile_base_ff  <= csr_pwdata;
            CSR_CODE_QUIRK: code_quirk_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_LAYER_MODE: csr_prdata = {31'd0, layer_mode_ff};
         CSR_SCROLL_X:   csr_prdata = {16'd0, scroll_x_ff};
         CSR_SCROLL_Y:   csr_prdata = {16'd0, scroll_y_ff};
         CSR_FIRST_LINE: csr_prdata = {24'd0, first_line_ff};
         CSR_END_LINE:   csr_prdata = {24'd0, end_line_ff};
         CSR_TILE_BASE:  csr_prdata = tile_base_ff;
         CSR_CODE_QUIRK: csr_prdata = {30'd0, code_quirk_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // walker and pipeline state
   logic                 busy_ff, busy_in;
   logic [5:0]           col_ff, col_in;
   logic [5:0]           fx_ff, fx_in;
   logic [5:0]           fy_ff, fy_in;
   logic [POS_W-1:0]     px_ff, px_in;
   logic [POS_W-1:0]     py_ff, py_in;
   logic                 clip_y_ff, clip_y_in;
   logic                 s1_valid_ff, s1_valid_in;
   col_meta_type         s1_meta_ff;
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_tile_address_ff;
   logic [PAL_W-1:0]     rsp_palette_ff;
   logic [FLIP_W-1:0]    rsp_flip_ff;
   logic [POS_W-1:0]     rsp_screen_x_ff;
   logic [POS_W-1:0]     rsp_screen_y_ff;
   logic                 rsp_needs_clip_ff;
   logic                 rsp_last_ff;

   logic [ENTRY_W-1:0]   map_mem [MAP_ENTRIES];

   logic                 req_fire, map_we, row_go;
   logic                 issue, s1_adv;
   logic [5:0]           cols_last;
   logic [POS_W-1:0]     size10;
   logic [13:0]          size14;
   logic [4:0]           phase_x, phase_y;
   logic [8:0]           sum_first, sum_last;
   logic [5:0]           first_row, last_row;
   logic signed [7:0]    row_y;
   logic                 in_band;
   logic [13:0]          ysz, ysz_end, py_full;
   logic                 clip_y_new;
   logic [5:0]           fx_start, sy_tile;
   logic [MAP_AW-1:0]    rd_addr;
   col_meta_type         meta_new;
   logic [CODE_W-1:0]    code_raw, code_fix;
   logic [ADDR_W-1:0]    code_shifted;

   assign req_bus.ready = !busy_ff;
   assign req_fire = req_bus.valid && !busy_ff;
   assign map_we   = req_fire && (req_bus.cmd == CMD_WRITE);
   assign row_go   = req_fire && (req_bus.cmd == CMD_ROW);

   // row setup from the scroll registers, worked out at acceptance
   always_comb begin
      if (layer_mode_ff) begin
         cols_last = COLS_LAST_32;
         size10    = 10'd32;
         size14    = 14'd32;
         phase_x   = scroll_x_ff[4:0];
         phase_y   = scroll_y_ff[4:0];
         fx_start  = scroll_x_ff[10:5];
         sy_tile   = scroll_y_ff[10:5];
      end else begin
         cols_last = COLS_LAST_8;
         size10    = 10'd8;
         size14    = 14'd8;
         phase_x   = {2'b00, scroll_x_ff[2:0]};
         phase_y   = {2'b00, scroll_y_ff[2:0]};
         fx_start  = scroll_x_ff[8:3];
         sy_tile   = scroll_y_ff[8:3];
      end
      sum_first = {1'b0, first_line_ff} + {4'd0, phase_y};
      sum_last  = {1'b0, end_line_ff} + {4'd0, phase_y};
      if (layer_mode_ff) begin
         first_row = {2'b00, sum_first[8:5]};
         last_row  = {2'b00, sum_last[8:5]};
      end else begin
         first_row = sum_first[8:3];
         last_row  = sum_last[8:3];
      end
      row_y   = $signed({2'b00, first_row}) - 8'sd1 + $signed({2'b00, req_bus.row_number});
      in_band = row_y < $signed({2'b00, last_row});
      if (layer_mode_ff)
         ysz = {{6{row_y[7]}}, row_y} << 5;
      else
         ysz = {{6{row_y[7]}}, row_y} << 3;
      ysz_end    = ysz + size14;
      clip_y_new = ($signed(ysz) < $signed({6'd0, first_line_ff}))
                || ($signed(ysz_end) >= $signed({6'd0, end_line_ff}));
      py_full    = ysz_end - {9'd0, phase_y};
   end

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign issue  = busy_ff && (!s1_valid_ff || s1_adv);

   always_comb begin
      busy_in   = busy_ff;
      col_in    = col_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      clip_y_in = clip_y_ff;
      if (row_go) begin
         busy_in   = in_band;
         col_in    = '0;
         fx_in     = fx_start;
         fy_in     = sy_tile + 6'd1 + row_y[5:0];
         px_in     = 10'd0 - {5'd0, phase_x};
         py_in     = py_full[POS_W-1:0];
         clip_y_in = clip_y_new;
      end else if (issue) begin
         col_in = col_ff + 6'd1;
         fx_in  = fx_ff + 6'd1;
         px_in  = px_ff + size10;
         if (col_ff == cols_last)
            busy_in = 1'b0;
      end
   end

   // map index interleaves column and row bits differently per mode
   always_comb begin
      if (layer_mode_ff)
         rd_addr = {fy_ff[5:3], fx_ff, fy_ff[2:0]};
      else
         rd_addr = {fy_ff[5], fx_ff, fy_ff[4:0]};
      meta_new.clip = (col_ff == 6'd0) || (col_ff == cols_last) || clip_y_ff;
      meta_new.last = (col_ff == cols_last);
      meta_new.px   = px_ff;
      meta_new.py   = py_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue)
         s1_valid_in = 1'b1;
      else if (s1_adv)
         s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      clip_y_ff <= clip_y_in;
      if (issue)
         s1_meta_ff <= meta_new;
   end

   // tile map: writes come only while the walker is idle, reads only while it runs
   always_ff @(posedge clock) begin
      if (map_we)
         map_mem[req_bus.entry_index] <= {req_bus.tile_code, req_bus.tile_attr[ATTR_W-1:0]};
      if (issue)
         rd_data_ff <= map_mem[rd_addr];
   end

   // draw command assembly
   always_comb begin
      code_raw = rd_data_ff[ENTRY_W-1:ATTR_W];
      code_fix = code_raw;
      case (quirk_type'(code_quirk_ff))
         QUIRK_SUB: if (code_raw >= QUIRK_SUB_FROM) code_fix = code_raw - QUIRK_DELTA;
         QUIRK_ADD: if (code_raw < QUIRK_ADD_BELOW) code_fix = code_raw + QUIRK_DELTA;
         default:   code_fix = code_raw;
      endcase
      if (layer_mode_ff)
         code_shifted = {7'd0, code_fix, 9'd0};
      else
         code_shifted = {10'd0, code_raw, 6'd0};
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_tile_address_ff <= code_shifted + tile_base_ff;
         rsp_palette_ff      <= (layer_mode_ff ? PAL_BASE_32 : PAL_BASE_8)
                              | {2'b00, rd_data_ff[4:0]};
         rsp_flip_ff         <= rd_data_ff[6:5];
         rsp_screen_x_ff     <= s1_meta_ff.px;
         rsp_screen_y_ff     <= s1_meta_ff.py;
         rsp_needs_clip_ff   <= s1_meta_ff.clip;
         rsp_last_ff         <= s1_meta_ff.last;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tile_address = rsp_tile_address_ff;
   assign rsp_bus.palette      = rsp_palette_ff;
   assign rsp_bus.flip         = rsp_flip_ff;
   assign rsp_bus.screen_x     = $signed(rsp_screen_x_ff);
   assign rsp_bus.screen_y     = $signed(rsp_screen_y_ff);
   assign rsp_bus.needs_clip   = rsp_needs_clip_ff;
   assign rsp_bus.last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(issue && map_we))
      else $error("map read and write in the same cycle");

   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      (row_go && !in_band) |=> !busy_ff)
      else $error("out of band row started a walk");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (col_ff <= cols_last))
      else $error("column counter ran past the row");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (issue && (col_ff == cols_last)) |=> !busy_ff)
      else $error("walker kept running after the last column");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_meta_ff)
                                    && $stable(rd_data_ff)))
      else $error("stalled read stage lost its beat");
`endif

endmodule

// ----- tb/sv/scroll_tilemap_fetch_tb.sv -----
// Testbench of the scroll tile map fetcher: map fill, directed rows, random phases, beat checks.
module scroll_tilemap_fetch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stf_pkg::*;

   localparam int ITEM_TARGET   = 350;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 30;

   localparam logic [15:0] SUB_THRESHOLD = 16'h5800;
   localparam logic [15:0] ADD_THRESHOLD = 16'h5600;
   localparam logic [15:0] REMAP_STEP    = 16'h4000;
   localparam logic [6:0]  PAL_8X8       = 7'h20;
   localparam logic [6:0]  PAL_32X32     = 7'h60;
   localparam logic [1:0]  QUIRK_SPARE   = 2'd3;

   typedef struct {
      logic        cmd;
      logic [11:0] entry;
      logic [15:0] code;
      logic [15:0] attr;
      logic [5:0]  row;
   } fetch_item_type;

   typedef struct {
      logic [31:0]       tile_address;
      logic [6:0]        palette;
      logic [1:0]        flip;
      logic signed [9:0] screen_x;
      logic signed [9:0] screen_y;
      logic              needs_clip;
      logic              last;
   } draw_cmd_type;

   typedef struct {
      logic        mode;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [7:0]  top;
      logic [7:0]  stop;
      logic [31:0] base;
      logic [1:0]  quirk;
   } layer_regs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   stf_req_if req_bus ();
   stf_rsp_if rsp_bus ();

   scroll_tilemap_fetch DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   layer_regs_type regs;
   logic [15:0]    tile_codes [MAP_ENTRIES];
   logic [6:0]     tile_attrs [MAP_ENTRIES];
   bit             filled [MAP_ENTRIES];
   int             filled_list [$];
   fetch_item_type fetch_items [$];
   draw_cmd_type   draws_due [$];
   fetch_item_type on_bus;
   bit             steady = 1'b0;
   int             items_sent = 0;
   int             hold_asks = 0;
   int             hold_taken = 0;
   int             hold_left = 0;
   int             mismatches = 0;
   int             quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Walk one tile row and queue the draw commands it must give.
   function automatic void walk_row(logic [5:0] row);
      int          shift, tile_px, cols, ix, iy, phase_x, phase_y;
      int          first_row, last_row, r, y, x, org_x, org_y, top, stop;
      bit          clip_y;
      logic [5:0]  fx, fy;
      logic [11:0] idx;
      logic [15:0] code;
      logic [6:0]  attr;
      draw_cmd_type d;
      shift   = regs.mode ? 5 : 3;
      tile_px = 1 << shift;
      cols    = regs.mode ? 12 : 48;
      ix      = int'(regs.sx >> shift) + 1;
      iy      = int'(regs.sy >> shift) + 1;
      phase_x = int'(regs.sx) & (tile_px - 1);
      phase_y = int'(regs.sy) & (tile_px - 1);
      top     = int'(regs.top);
      stop    = int'(regs.stop);
      r       = int'(row);
      first_row = (top + phase_y) >> shift;
      last_row  = (stop + phase_y) >> shift;
      y = first_row - 1 + r;
      if (y >= last_row)
         return;
      org_x  = tile_px - phase_x;
      org_y  = tile_px - phase_y;
      clip_y = (y * tile_px < top) || (y * tile_px + tile_px >= stop);
      for (x = -1; x < cols; x++) begin
         fx  = 6'(ix + x);
         fy  = 6'(iy + y);
         // column and row bits interleave differently per tile size
         idx = regs.mode ? {fy[5:3], fx, fy[2:0]} : {fy[5], fx, fy[4:0]};
         code = tile_codes[idx];
         attr = tile_attrs[idx];
         if (regs.mode) begin
            if (regs.quirk == QUIRK_SUB && code >= SUB_THRESHOLD)
               code = code - REMAP_STEP;
            else if (regs.quirk == QUIRK_ADD && code < ADD_THRESHOLD)
               code = code + REMAP_STEP;
            d.tile_address = ({16'h0000, code} << 9) + regs.base;
            d.palette      = PAL_32X32 | {2'b00, attr[4:0]};
         end else begin
            d.tile_address = ({16'h0000, code} << 6) + regs.base;
            d.palette      = PAL_8X8 | {2'b00, attr[4:0]};
         end
         d.flip       = attr[6:5];
         d.screen_x   = 10'(org_x + x * tile_px);
         d.screen_y   = 10'(org_y + y * tile_px);
         d.needs_clip = (x < 0) || (x >= cols - 1) || clip_y;
         d.last       = (x == cols - 1);
         draws_due.push_back(d);
      end
   endfunction

   // Map entries that a row reads under the current registers; none when it draws nothing.
   function automatic void row_entries(input logic [5:0] row, output int list [$]);
      int          shift, tile_px, cols, ix, iy, phase_y, first_row, last_row, y, x;
      logic [5:0]  fx, fy;
      logic [11:0] idx;
      shift     = regs.mode ? 5 : 3;
      tile_px   = 1 << shift;
      cols      = regs.mode ? 12 : 48;
      ix        = int'(regs.sx >> shift) + 1;
      iy        = int'(regs.sy >> shift) + 1;
      phase_y   = int'(regs.sy) & (tile_px - 1);
      first_row = (int'(regs.top) + phase_y) >> shift;
      last_row  = (int'(regs.stop) + phase_y) >> shift;
      y         = first_row - 1 + int'(row);
      list.delete();
      if (y >= last_row)
         return;
      for (x = -1; x < cols; x++) begin
         fx  = 6'(ix + x);
         fy  = 6'(iy + y);
         idx = regs.mode ? {fy[5:3], fx, fy[2:0]} : {fy[5], fx, fy[4:0]};
         list.push_back(int'(idx));
      end
   endfunction

   // Entries of the row not yet written; -1 when the row draws nothing.
   function automatic int row_missing(logic [5:0] row);
      int list [$];
      int n;
      row_entries(row, list);
      if (list.size() == 0)
         return -1;
      n = 0;
      foreach (list[k])
         if (!filled[list[k]])
            n++;
      return n;
   endfunction

   // Codes near the remap thresholds turn up often.
   function automatic logic [15:0] rand_code();
      if ($urandom_range(99) < 30)
         return 16'($urandom_range(16'h5900, 16'h5500));
      return 16'($urandom);
   endfunction

   function automatic void push_write(logic [11:0] entry, logic [15:0] code, logic [15:0] attr);
      fetch_item_type it;
      it.cmd   = CMD_WRITE;
      it.entry = entry;
      it.code  = code;
      it.attr  = attr;
      it.row   = 6'($urandom_range(63));
      fetch_items.push_back(it);
      if (!filled[entry]) begin
         filled[entry] = 1'b1;
         filled_list.push_back(int'(entry));
      end
      items_sent++;
   endfunction

   function automatic void push_row(logic [5:0] row);
      fetch_item_type it;
      it.cmd   = CMD_ROW;
      it.entry = 12'($urandom_range(MAP_ENTRIES - 1));
      it.code  = 16'($urandom);
      it.attr  = 16'($urandom);
      it.row   = row;
      fetch_items.push_back(it);
      items_sent++;
   endfunction

   // Write whatever the row reads that holds nothing yet, then draw it.
   function automatic void push_row_filled(logic [5:0] row);
      int list [$];
      row_entries(row, list);
      foreach (list[k])
         if (!filled[list[k]])
            push_write(12'(list[k]), rand_code(), 16'($urandom));
      push_row(row);
   endfunction

   // Mostly rows whose entries are written already, so few fill writes are needed.
   function automatic logic [5:0] pick_row();
      int idle_rows [$];
      int ready_rows [$];
      int best, best_missing, m, r;
      best         = -1;
      best_missing = 0;
      for (r = 0; r < 64; r++) begin
         m = row_missing(6'(r));
         if (m < 0)
            idle_rows.push_back(r);
         else if (m == 0)
            ready_rows.push_back(r);
         else if (best < 0 || m < best_missing) begin
            best         = r;
            best_missing = m;
         end
      end
      if (idle_rows.size() > 0
          && ($urandom_range(99) < 20 || (ready_rows.size() == 0 && best < 0)))
         return 6'(idle_rows[$urandom_range(idle_rows.size() - 1)]);
      if (ready_rows.size() > 0 && ($urandom_range(99) < 85 || best < 0))
         return 6'(ready_rows[$urandom_range(ready_rows.size() - 1)]);
      if (best >= 0)
         return 6'(best);
      return 6'($urandom_range(63));
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_LAYER_MODE: regs.mode  = value[0];
         CSR_SCROLL_X:   regs.sx    = value[15:0];
         CSR_SCROLL_Y:   regs.sy    = value[15:0];
         CSR_FIRST_LINE: regs.top   = value[7:0];
         CSR_END_LINE:   regs.stop  = value[7:0];
         CSR_TILE_BASE:  regs.base  = value;
         CSR_CODE_QUIRK: regs.quirk = value[1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic mode, logic [15:0] sx, logic [15:0] sy, logic [7:0] top,
                             logic [7:0] stop, logic [31:0] base, logic [1:0] quirk);
      csr_write(CSR_LAYER_MODE, {31'd0, mode});
      csr_write(CSR_SCROLL_X, {16'd0, sx});
      csr_write(CSR_SCROLL_Y, {16'd0, sy});
      csr_write(CSR_FIRST_LINE, {24'd0, top});
      csr_write(CSR_END_LINE, {24'd0, stop});
      csr_write(CSR_TILE_BASE, base);
      csr_write(CSR_CODE_QUIRK, {30'd0, quirk});
   endtask

   // Sampled mid-cycle, once the driver's updates at the edge have settled.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (fetch_items.size() != 0 || req_bus.valid || draws_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.cmd         <= CMD_WRITE;
         req_bus.entry_index <= '0;
         req_bus.tile_code   <= '0;
         req_bus.tile_attr   <= '0;
         req_bus.row_number  <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (on_bus.cmd == CMD_WRITE) begin
               tile_codes[on_bus.entry] = on_bus.code;
               tile_attrs[on_bus.entry] = on_bus.attr[6:0];
            end else begin
               walk_row(on_bus.row);
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (fetch_items.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
               on_bus = fetch_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.cmd         <= on_bus.cmd;
               req_bus.entry_index <= on_bus.entry;
               req_bus.tile_code   <= on_bus.code;
               req_bus.tile_attr   <= on_bus.attr;
               req_bus.row_number  <= on_bus.row;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      draw_cmd_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (draws_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: draw command beat with none due, address %h",
                           $time, rsp_bus.tile_address);
            end else begin
               due = draws_due.pop_front();
               check_field("tile_address", due.tile_address, rsp_bus.tile_address);
               check_field("palette", 32'(due.palette), 32'(rsp_bus.palette));
               check_field("flip", 32'(due.flip), 32'(rsp_bus.flip));
               check_field("screen_x", 32'(due.screen_x), 32'(rsp_bus.screen_x));
               check_field("screen_y", 32'(due.screen_y), 32'(rsp_bus.screen_y));
               check_field("needs_clip", 32'(due.needs_clip), 32'(rsp_bus.needs_clip));
               check_field("last", 32'(due.last), 32'(rsp_bus.last));
            end
         end
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
            $display("scroll_tilemap_fetch_tb failed");
            $finish;
         end
      end
   end

   initial begin : sequencer
      int          n_items, phase_no;
      logic        mode;
      logic [15:0] sx, sy;
      logic [7:0]  top, stop;
      logic [31:0] base;
      logic [1:0]  quirk;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      regs.mode  = 1'b0;
      regs.sx    = '0;
      regs.sy    = '0;
      regs.top   = 8'd0;
      regs.stop  = 8'd224;
      regs.base  = '0;
      regs.quirk = QUIRK_NONE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every row writes the entries it reads beforehand, so none is read unwritten
      // reset registers: 8x8, no scroll, band 0..224
      push_write(12'd0, 16'h0000, 16'h0000);
      push_write(12'(MAP_ENTRIES - 1), 16'hFFFF, 16'hFFFF);
      push_row_filled(6'd0);
      push_row_filled(6'd28);
      push_row_filled(6'd29);
      push_row_filled(6'd63);
      wait_drained();

      // full scroll: the row above the band reads the top corner entry
      set_config(1'b0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd224, 32'hFFFF_FFC0, QUIRK_NONE);
      push_row_filled(6'd0);
      push_row_filled(6'd1);
      push_row_filled(6'd63);
      wait_drained();

      // 32x32: codes either side of both remap thresholds in the first columns
      set_config(1'b1, 16'h0000, 16'h0000, 8'd0, 8'd224, 32'hFFFF_FE00, QUIRK_SUB);
      push_write(12'd0, 16'h57FF, 16'h0000);
      push_write(12'd8, 16'h5800, 16'h007F);
      push_write(12'd16, 16'h55FF, 16'hFF80);
      push_write(12'd24, 16'h5600, 16'h0035);
      push_write(12'd32, 16'hFFFF, 16'hFFFF);
      push_write(12'd40, 16'h0000, 16'h004A);
      push_row_filled(6'd0);
      push_row_filled(6'd7);
      push_row_filled(6'd8);
      wait_drained();
      set_config(1'b1, 16'h0000, 16'h0000, 8'd0, 8'd224, 32'hFFFF_FE00, QUIRK_ADD);
      push_row_filled(6'd0);
      wait_drained();
      set_config(1'b1, 16'h0000, 16'h0000, 8'd0, 8'd224, 32'hFFFF_FE00, QUIRK_SPARE);
      push_row_filled(6'd0);
      wait_drained();

      // inverted band: nothing drawn
      set_config(1'b0, 16'h1234, 16'h0005, 8'd255, 8'd0, 32'h0000_0000, QUIRK_NONE);
      push_row_filled(6'd0);
      push_row_filled(6'd40);
      wait_drained();

      // band past the usual screen height
      set_config(1'b0, 16'h0003, 16'h0000, 8'd224, 8'd255, 32'h0000_1000, QUIRK_NONE);
      push_row_filled(6'd0);
      push_row_filled(6'd4);

      phase_no = 0;
      while (items_sent < ITEM_TARGET || phase_no < 4) begin
         wait_drained();
         steady = (phase_no == 1);
         mode   = 1'($urandom_range(1));
         sx     = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                           : 16'($urandom);
         sy     = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                           : 16'($urandom);
         case ($urandom_range(9))
            0: begin
               top  = 8'($urandom_range(255));
               stop = 8'($urandom_range(255));
            end
            1: begin
               top  = 8'd0;
               stop = 8'd224;
            end
            default: begin
               top  = 8'($urandom_range(200));
               stop = 8'($urandom_range(224, top));
            end
         endcase
         // the long receiver hold wants a proper band so beats back up
         if (phase_no == 3) begin
            top  = 8'd0;
            stop = 8'd224;
         end
         base  = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : $urandom;
         quirk = 2'($urandom_range(3));
         set_config(mode, sx, sy, top, stop, base, quirk);
         if (phase_no == 3)
            hold_asks++;

         n_items = (phase_no == 1) ? 30 : $urandom_range(16, 8);
         repeat (n_items) begin
            if ($urandom_range(99) < 55)
               push_row_filled(pick_row());
            else if (filled_list.size() > 0 && $urandom_range(99) < 70)
               push_write(12'(filled_list[$urandom_range(filled_list.size() - 1)]),
                          rand_code(), 16'($urandom));
            else
               push_write(12'($urandom), rand_code(), 16'($urandom));
         end
         phase_no++;
      end
      wait_drained();

      if (mismatches == 0)
         $display("scroll_tilemap_fetch_tb passed");
      else
         $display("scroll_tilemap_fetch_tb failed");
      $finish;
   end

endmodule

// ----- scroll_tilemap_fetch.f -----
rtl/stf_pkg.sv
rtl/stf_req_if.sv
rtl/stf_rsp_if.sv
rtl/scroll_tilemap_fetch.sv
tb/sv/scroll_tilemap_fetch_tb.sv
